// ----- hdl/pepv_pkg.sv -----
package pepv_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_ZERO_HITS = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] doc_id;
        logic        hit_present;
        logic [15:0] hit_raw;
        logic        is_field_hit;
        logic [5:0]  field_kind;
        logic [15:0] position;
        logic [7:0]  hit_index;
        logic        entry_end;
        t_status     status;
        logic        stream_end;
    } t_out_item;

endpackage

// ----- hdl/posting_entry_parse_validate_top.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in  (t_in_item: data_byte, last_byte)
// result    out        o_out_valid / i_out_stall  o_out (t_out_item: decoded hit and verdict)
//
// One byte is taken per cycle while o_in_stall is low; a result, when the byte gives one, is
// registered into a two-entry output buffer. The byte is decoded against the parser state
// in the same cycle it is taken.
// Reset (i_rst_n low at a rising edge) clears the parser and empties the buffer.
// o_in_stall rises only once both output entries are held; it falls as soon as the
// consumer takes one.
module posting_entry_parse_validate_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pepv_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pepv_pkg::t_out_item o_out
);
    import pepv_pkg::*;

    logic      in_take;
    logic      out_take;
    logic      res_valid;
    logic      push;
    t_out_item res;

    // output register and skid entry behind it
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    // stall upstream only while the skid entry is occupied
    assign o_in_stall  = r_skid_valid;
    assign in_take     = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign push        = in_take && res_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    pepv_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_take),
        .i_item      (i_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                // advance the skid entry; no transfer arrives while it is held
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
                r_out       <= res;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else begin
                // hold the new result behind the stalled one
                r_skid_valid <= 1'b1;
                r_skid       <= res;
            end
        end
    end

endmodule

// ----- hdl/pepv_parser.sv -----
module pepv_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  pepv_pkg::t_in_item i_item,
    output logic              o_res_valid,
    output pepv_pkg::t_out_item o_res
);
    import pepv_pkg::*;

    typedef enum logic [2:0] {
        PH_DOC0  = 3'd0,
        PH_DOC1  = 3'd1,
        PH_DOC2  = 3'd2,
        PH_DOC3  = 3'd3,
        PH_COUNT = 3'd4,
        PH_HIGH  = 3'd5,
        PH_LOW   = 3'd6
    } t_phase;

    localparam logic [15:0] FIELD_MAX_FLOOR = 16'hbfff;
    localparam logic [15:0] BODY_TOLERATED  = 16'h3fff;
    localparam logic [7:0]  FIELD_POS_MAX   = 8'hff;

    t_phase      r_phase, n_phase;
    logic [31:0] r_doc, n_doc;
    logic [7:0]  r_expected, n_expected;
    logic [7:0]  r_seen, n_seen;
    logic [7:0]  r_high, n_high;
    logic [15:0] r_prev, n_prev;
    logic        r_prev_valid, n_prev_valid;
    logic        r_halted, n_halted;

    logic [15:0] word;
    logic [7:0]  seen_inc;
    logic        dup;
    logic        done;
    logic        res_hit;
    logic        res_ends;
    t_status     res_status;
    logic        res_last;
    logic [31:0] res_doc;
    logic        field;

    assign word     = {r_high, i_item.data_byte};
    assign seen_inc = r_seen + 8'd1;
    assign dup      = r_prev_valid && (r_prev == word)
                      && ((word < FIELD_MAX_FLOOR) || (word[7:0] != FIELD_POS_MAX))
                      && (word != BODY_TOLERATED);
    assign done     = (seen_inc >= r_expected);

    always_comb begin
        n_phase      = r_phase;
        n_doc        = r_doc;
        n_expected   = r_expected;
        n_seen       = r_seen;
        n_high       = r_high;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_halted     = r_halted;
        o_res_valid  = 1'b0;
        res_hit      = 1'b0;
        res_ends     = 1'b0;
        res_status   = ST_OK;
        res_last     = i_item.last_byte;
        res_doc      = r_doc;

        if (r_halted) begin
            // drop everything until the closing byte
            o_res_valid = i_item.last_byte;
        end else begin
            unique case (r_phase)
                PH_DOC0, PH_DOC1, PH_DOC2, PH_DOC3: begin
                    n_doc       = {r_doc[23:0], i_item.data_byte};
                    n_phase     = t_phase'(r_phase + 3'd1);
                    res_doc     = n_doc;
                    o_res_valid = i_item.last_byte;
                    res_ends    = 1'b1;
                    res_status  = ST_TRUNCATED;
                end
                PH_COUNT: begin
                    n_expected   = i_item.data_byte;
                    n_seen       = 8'd0;
                    n_prev_valid = 1'b0;
                    n_phase      = PH_HIGH;
                    res_ends     = 1'b1;
                    if (i_item.data_byte == 8'd0) begin
                        o_res_valid = 1'b1;
                        res_status  = ST_ZERO_HITS;
                        n_halted    = 1'b1;
                    end else begin
                        o_res_valid = i_item.last_byte;
                        res_status  = ST_TRUNCATED;
                    end
                end
                PH_HIGH: begin
                    n_high      = i_item.data_byte;
                    n_phase     = PH_LOW;
                    o_res_valid = i_item.last_byte;
                    res_ends    = 1'b1;
                    res_status  = ST_TRUNCATED;
                end
                PH_LOW: begin
                    n_seen       = seen_inc;
                    n_prev       = word;
                    n_prev_valid = 1'b1;
                    o_res_valid  = 1'b1;
                    res_hit      = 1'b1;
                    if (dup) begin
                        res_ends   = 1'b1;
                        res_status = ST_DUPLICATE;
                        n_halted   = 1'b1;
                    end else if (done) begin
                        res_ends     = 1'b1;
                        n_phase      = PH_DOC0;
                        n_doc        = 32'd0;
                        n_prev_valid = 1'b0;
                    end else if (i_item.last_byte) begin
                        res_ends   = 1'b1;
                        res_status = ST_TRUNCATED;
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end
                default: begin
                    n_phase = PH_DOC0;
                end
            endcase
        end

        // the closing byte returns the parser to its reset state
        if (i_item.last_byte) begin
            n_phase      = PH_DOC0;
            n_doc        = 32'd0;
            n_expected   = 8'd0;
            n_seen       = 8'd0;
            n_high       = 8'd0;
            n_prev       = 16'd0;
            n_prev_valid = 1'b0;
            n_halted     = 1'b0;
        end
    end

    assign field = res_hit && (word[15:14] == 2'b11);

    always_comb begin
        o_res.doc_id       = res_doc;
        o_res.hit_present  = res_hit;
        o_res.hit_raw      = res_hit ? word : 16'd0;
        o_res.is_field_hit = field;
        o_res.field_kind   = field ? word[13:8] : 6'd0;
        o_res.position     = res_hit ? (field ? {8'd0, word[7:0]} : word) : 16'd0;
        o_res.hit_index    = res_hit ? r_seen : 8'd0;
        o_res.entry_end    = res_ends;
        o_res.status       = res_status;
        o_res.stream_end   = res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_DOC0;
            r_doc        <= 32'd0;
            r_expected   <= 8'd0;
            r_seen       <= 8'd0;
            r_high       <= 8'd0;
            r_prev       <= 16'd0;
            r_prev_valid <= 1'b0;
            r_halted     <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_doc        <= n_doc;
            r_expected   <= n_expected;
            r_seen       <= n_seen;
            r_high       <= n_high;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_halted     <= n_halted;
        end
    end

endmodule
